// ===== rtl/alte_pkg.sv =====
// Shared types and constants for the array list table engine.
`default_nettype none
package alte_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 4;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 7;
    localparam int IN_FIELDS_W  = 3 * DATA_W + POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + 2 * DATA_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_HEAD = 4'd0,
        FN_INS_TAIL = 4'd1,
        FN_INS_POS  = 4'd2,
        FN_INS_KEY  = 4'd3,
        FN_DEL_HEAD = 4'd4,
        FN_DEL_TAIL = 4'd5,
        FN_DEL_POS  = 4'd6,
        FN_DEL_KEY  = 4'd7,
        FN_GET_POS  = 4'd8,
        FN_GET_KEY  = 4'd9,
        FN_EXISTS   = 4'd10
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_NOKEY  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_INS  = 2'd1,
        SH_DEL  = 2'd2
    } shift_t;

    typedef struct packed {
        logic              cmp_en;
        logic              upd_en;
        shift_t            shift;
        logic              by_key;
        logic [DATA_W-1:0] skey;
        logic [DATA_W-1:0] new_key;
        logic [DATA_W-1:0] new_wt;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/alte_cell.sv =====
// One table slot: holds an entry, compares its key and shifts with its neighbors.
`default_nettype none
module alte_cell
    import alte_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX      = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  wire logic              clk,
    input  wire cell_ctl_t         ctl,
    input  wire logic [CNT_W-1:0]  tgt,
    input  wire logic [CNT_W-1:0]  cnt,
    input  wire logic [DATA_W-1:0] left_key,
    input  wire logic [DATA_W-1:0] left_wt,
    input  wire logic [DATA_W-1:0] right_key,
    input  wire logic [DATA_W-1:0] right_wt,
    input  wire logic              hit_in,
    output logic                   hit_out,
    output logic                   sel,
    output logic [DATA_W-1:0]      cell_key,
    output logic [DATA_W-1:0]      cell_wt
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] wt_reg, wt_next;
    logic              match_reg, match_next;

    always_comb
    begin
        sel        = ctl.by_key ? (match_reg & ~hit_in) : (tgt == MY_IDX);
        hit_out    = hit_in | sel;
        match_next = ctl.cmp_en ? ((MY_IDX < cnt) && (key_reg == ctl.skey)) : match_reg;
        key_next   = key_reg;
        wt_next    = wt_reg;
        if (ctl.upd_en)
        begin
            unique case (ctl.shift)
                SH_INS:
                begin
                    if (sel)
                    begin
                        key_next = ctl.new_key;
                        wt_next  = ctl.new_wt;
                    end
                    else if (hit_in)
                    begin
                        key_next = left_key;
                        wt_next  = left_wt;
                    end
                end
                SH_DEL:
                begin
                    if (sel || hit_in)
                    begin
                        key_next = right_key;
                        wt_next  = right_wt;
                    end
                end
                default:
                begin
                    key_next = key_reg;
                    wt_next  = wt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        wt_reg    <= wt_next;
        match_reg <= match_next;
    end

    assign cell_key = key_reg;
    assign cell_wt  = wt_reg;

endmodule
`default_nettype wire

// ===== rtl/array_list_table_engine_top.sv =====
// Array list table engine top level: request sequencer, cell row and result register.
// Each request takes a key compare state, then a shift/update state across the cell row,
// where its result is registered; the next request is accepted in that update state,
// unless the result register still holds an unaccepted result.
// Reset: rst_n low empties the table (count zero); entry contents are left as they are.
`default_nettype none
module array_list_table_engine_top
    import alte_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // item_key[31:0], item_weight[63:32], search_key[95:64], position[101:96]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // func[3:0]
    input  wire logic [FUNC_W-1:0]      s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status[2:0], out_key[34:3], out_weight[66:35], count[73:67]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_EXEC = 2'd2
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    func_t                    func_reg;
    logic [DATA_W-1:0]        ikey_reg, iwt_reg, skey_reg;
    logic [POS_W-1:0]         pos_reg;

    logic                     in_xfer, exec_go;
    cell_ctl_t                ctl;
    logic [CNT_W-1:0]         tgt;
    logic [CAPACITY:0]        hit;
    logic [CAPACITY-1:0]      sel;
    logic [DATA_W-1:0]        ckey [CAPACITY];
    logic [DATA_W-1:0]        cwt  [CAPACITY];
    logic [DATA_W-1:0]        rd_key, rd_wt;
    logic                     found, full, empty;
    logic [WIDE_W-1:0]        pos_w, cnt_w, cnt_out;
    status_t                  st;
    logic                     do_ins, do_del, do_rd;

    assign exec_go  = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE) || exec_go;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func_t'(s_tuser);
            ikey_reg <= s_tdata[DATA_W-1:0];
            iwt_reg  <= s_tdata[2*DATA_W-1:DATA_W];
            skey_reg <= s_tdata[3*DATA_W-1:2*DATA_W];
            pos_reg  <= s_tdata[3*DATA_W+POS_W-1:3*DATA_W];
        end
    end

    assign full  = (count_reg == CAP_CNT);
    assign empty = (count_reg == '0);
    assign pos_w = WIDE_W'(pos_reg);
    assign cnt_w = WIDE_W'(count_reg);
    assign found = hit[CAPACITY];

    always_comb
    begin
        st     = ST_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        do_rd  = 1'b0;
        tgt    = pos_w[CNT_W-1:0];
        unique case (func_reg)
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS, FN_INS_KEY:
            begin
                if (func_reg == FN_INS_HEAD)
                    tgt = '0;
                else if (func_reg == FN_INS_TAIL)
                    tgt = count_reg;
                priority if (full)
                    st = ST_FULL;
                else if ((func_reg == FN_INS_POS) && (pos_w > cnt_w))
                    st = ST_BADPOS;
                else if ((func_reg == FN_INS_KEY) && !found)
                    st = ST_NOKEY;
                else
                    do_ins = 1'b1;
            end
            FN_DEL_HEAD, FN_DEL_TAIL:
            begin
                tgt = (func_reg == FN_DEL_HEAD) ? '0 : (count_reg - 1'b1);
                if (empty)
                    st = ST_EMPTY;
                else
                begin
                    do_del = 1'b1;
                    do_rd  = 1'b1;
                end
            end
            FN_DEL_POS:
            begin
                if (pos_w >= cnt_w)
                    st = ST_BADPOS;
                else
                begin
                    do_del = 1'b1;
                    do_rd  = 1'b1;
                end
            end
            FN_DEL_KEY:
            begin
                if (!found)
                    st = ST_NOKEY;
                else
                begin
                    do_del = 1'b1;
                    do_rd  = 1'b1;
                end
            end
            FN_GET_POS:
            begin
                if (pos_w >= cnt_w)
                    st = ST_BADPOS;
                else
                    do_rd = 1'b1;
            end
            FN_GET_KEY:
            begin
                if (!found)
                    st = ST_BADPOS;
                else
                    do_rd = 1'b1;
            end
            FN_EXISTS:
            begin
                if (!found)
                    st = ST_NOKEY;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        ctl.cmp_en  = (state_reg == S_CMP);
        ctl.upd_en  = exec_go && (do_ins || do_del);
        ctl.shift   = do_ins ? SH_INS : (do_del ? SH_DEL : SH_HOLD);
        ctl.by_key  = (func_reg == FN_INS_KEY) || (func_reg == FN_DEL_KEY) ||
                      (func_reg == FN_GET_KEY) || (func_reg == FN_EXISTS);
        ctl.skey    = skey_reg;
        ctl.new_key = ikey_reg;
        ctl.new_wt  = iwt_reg;
    end

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lkey, lwt, rkey, rwt;
        if (i == 0)
        begin : g_first
            assign lkey = '0;
            assign lwt  = '0;
        end
        else
        begin : g_mid_l
            assign lkey = ckey[i-1];
            assign lwt  = cwt[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign rkey = '0;
            assign rwt  = '0;
        end
        else
        begin : g_mid_r
            assign rkey = ckey[i+1];
            assign rwt  = cwt[i+1];
        end

        alte_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .tgt       (tgt),
            .cnt       (count_reg),
            .left_key  (lkey),
            .left_wt   (lwt),
            .right_key (rkey),
            .right_wt  (rwt),
            .hit_in    (hit[i]),
            .hit_out   (hit[i+1]),
            .sel       (sel[i]),
            .cell_key  (ckey[i]),
            .cell_wt   (cwt[i])
        );
    end

    always_comb
    begin
        rd_key = '0;
        rd_wt  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_key = rd_key | (sel[i] ? ckey[i] : '0);
            rd_wt  = rd_wt  | (sel[i] ? cwt[i]  : '0);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cnt_out       = cnt_w;
        if (m_tready)
            m_tvalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = in_xfer ? S_CMP : S_IDLE;
                    if (do_ins)
                        count_next = count_reg + 1'b1;
                    else if (do_del)
                        count_next = count_reg - 1'b1;
                    cnt_out       = WIDE_W'(count_next);
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({cnt_out[COUNT_W-1:0],
                                                  do_rd ? rd_wt  : '0,
                                                  do_rd ? rd_key : '0,
                                                  st});
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== rtl/alte_check.sv =====
// Port-level checker for the array list table engine, bound to the top level.
`default_nettype none
module alte_check
    import alte_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [DATA_W-1:0]   okey, owt;
    logic [COUNT_W-1:0]  ocnt;

    assign st   = m_tdata[STATUS_W-1:0];
    assign okey = m_tdata[STATUS_W+DATA_W-1:STATUS_W];
    assign owt  = m_tdata[STATUS_W+2*DATA_W-1:STATUS_W+DATA_W];
    assign ocnt = m_tdata[STATUS_W+2*DATA_W+COUNT_W-1:STATUS_W+2*DATA_W];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken during compare cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st != ST_OK) |-> (okey == '0) && (owt == '0))
        else $error("failed request carries entry data");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == ST_EMPTY) |-> (ocnt == '0))
        else $error("empty status with nonzero count");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st <= ST_NOKEY))
        else $error("status code out of range");

endmodule

bind array_list_table_engine_top alte_check u_alte_check (.*);
`default_nettype wire

// ===== tb/array_list_table_engine_top_tb.sv =====
// Self-checking testbench for the array list table engine: streamed requests against a predicted table.
`default_nettype none
module array_list_table_engine_top_tb;
    import alte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX = 10;
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = FUNC_W'(FN_EXISTS + 1);
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = '1;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] search_key;
        logic [DATA_W-1:0] item_weight;
        logic [DATA_W-1:0] item_key;
    } req_fields_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        req_fields_t       fields;
    } table_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [DATA_W-1:0]   out_weight;
        logic [DATA_W-1:0]   out_key;
        logic [STATUS_W-1:0] status;
    } table_result_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    table_req_t    pending_reqs[$];
    table_result_t expected_results[$];
    table_req_t    next_req;
    table_result_t got_result;
    table_result_t want_result;

    logic [DATA_W-1:0] tbl_key[CAPACITY];
    logic [DATA_W-1:0] tbl_weight[CAPACITY];
    int                tbl_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;

    array_list_table_engine_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int find_entry(logic [DATA_W-1:0] k);
        int i;
        for (i = 0; i < tbl_count; i++)
        begin
            if (tbl_key[i] == k)
                return i;
        end
        return tbl_count;
    endfunction

    function automatic void insert_entry(int p, logic [DATA_W-1:0] k, logic [DATA_W-1:0] w);
        int i;
        for (i = tbl_count; i > p; i--)
        begin
            tbl_key[i] = tbl_key[i-1];
            tbl_weight[i] = tbl_weight[i-1];
        end
        tbl_key[p] = k;
        tbl_weight[p] = w;
        tbl_count++;
    endfunction

    function automatic table_result_t take_entry(int p);
        table_result_t res;
        int i;
        res = '0;
        res.out_key = tbl_key[p];
        res.out_weight = tbl_weight[p];
        for (i = p; i + 1 < tbl_count; i++)
        begin
            tbl_key[i] = tbl_key[i+1];
            tbl_weight[i] = tbl_weight[i+1];
        end
        tbl_count--;
        return res;
    endfunction

    function automatic table_result_t apply_request(logic [FUNC_W-1:0] func, req_fields_t f);
        table_result_t res;
        int p;
        res = '0;
        res.status = ST_OK;
        case (func)
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS, FN_INS_KEY:
            begin
                if (tbl_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    p = tbl_count;
                    if (func == FN_INS_HEAD)
                        p = 0;
                    else if (func == FN_INS_POS)
                        p = f.position;
                    else if (func == FN_INS_KEY)
                        p = find_entry(f.search_key);
                    if (func == FN_INS_POS && p > tbl_count)
                        res.status = ST_BADPOS;
                    else if (func == FN_INS_KEY && p >= tbl_count)
                        res.status = ST_NOKEY;
                    else
                        insert_entry(p, f.item_key, f.item_weight);
                end
            end
            FN_DEL_HEAD, FN_DEL_TAIL:
            begin
                if (tbl_count == 0)
                    res.status = ST_EMPTY;
                else
                    res = take_entry(func == FN_DEL_HEAD ? 0 : tbl_count - 1);
            end
            FN_DEL_POS:
            begin
                if (f.position >= tbl_count)
                    res.status = ST_BADPOS;
                else
                    res = take_entry(f.position);
            end
            FN_DEL_KEY:
            begin
                p = find_entry(f.search_key);
                if (p >= tbl_count)
                    res.status = ST_NOKEY;
                else
                    res = take_entry(p);
            end
            FN_GET_POS:
            begin
                if (f.position >= tbl_count)
                    res.status = ST_BADPOS;
                else
                begin
                    res.out_key = tbl_key[f.position];
                    res.out_weight = tbl_weight[f.position];
                end
            end
            FN_GET_KEY:
            begin
                p = find_entry(f.search_key);
                if (p >= tbl_count)
                    res.status = ST_BADPOS;
                else
                begin
                    res.out_key = tbl_key[p];
                    res.out_weight = tbl_weight[p];
                end
            end
            FN_EXISTS:
            begin
                if (find_entry(f.search_key) >= tbl_count)
                    res.status = ST_NOKEY;
            end
            default:
            begin
            end
        endcase
        res.count = tbl_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic table_req_t make_req(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] ikey,
                                            logic [DATA_W-1:0] iwt, logic [DATA_W-1:0] skey,
                                            int pos);
        table_req_t r;
        r.func = func;
        r.fields.item_key = ikey;
        r.fields.item_weight = iwt;
        r.fields.search_key = skey;
        r.fields.position = pos[POS_W-1:0];
        return r;
    endfunction

    // Draw from a small key pool most of the time so searches hit and duplicates occur.
    function automatic logic [DATA_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    function automatic table_req_t random_req(int ins_pct, int del_pct);
        int roll;
        logic [FUNC_W-1:0] func;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            func = FUNC_W'($urandom_range(FN_INS_HEAD, FN_INS_KEY));
        else if (roll < ins_pct + del_pct)
            func = FUNC_W'($urandom_range(FN_DEL_HEAD, FN_DEL_KEY));
        else if (roll < 97)
            func = FUNC_W'($urandom_range(FN_GET_POS, FN_EXISTS));
        else
            func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        return make_req(func, pick_key(), $urandom(), pick_key(),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, CAPACITY - 1)
                                                    : $urandom_range(0, 15));
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_req.func;
                s_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, next_req.fields};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Predict on request transfer, then check any result transfer at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser, s_tdata[IN_FIELDS_W-1:0]));
            if (m_tvalid && m_tready)
            begin
                got_result = m_tdata[OUT_FIELDS_W-1:0];
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected result: status %0d key %h weight %h count %0d",
                                 got_result.status, got_result.out_key,
                                 got_result.out_weight, got_result.count);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.status !== want_result.status
                        || got_result.out_key !== want_result.out_key
                        || got_result.out_weight !== want_result.out_weight
                        || got_result.count !== want_result.count)
                    begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                        begin
                            $write("mismatch: exp status %0d key %h weight %h count %0d,",
                                   want_result.status, want_result.out_key,
                                   want_result.out_weight, want_result.count);
                            $display(" got status %0d key %h weight %h count %0d",
                                     got_result.status, got_result.out_key,
                                     got_result.out_weight, got_result.count);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("array_list_table_engine_top verification failed");
            $finish;
        end
    end

    initial
    begin
        int send_pct[4];
        int recv_pct[4];
        int ph;
        send_pct = '{0, 70, 0, 31};
        recv_pct = '{0, 0, 70, 31};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        pending_reqs.push_back(make_req(FN_DEL_HEAD, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_DEL_TAIL, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_DEL_POS, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_GET_POS, 0, 0, 0, CAPACITY - 1));
        pending_reqs.push_back(make_req(FN_GET_KEY, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_EXISTS, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_DEL_KEY, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_INS_KEY, 1, 1, 0, 0));
        pending_reqs.push_back(make_req(FN_INS_POS, 1, 1, 0, 1));
        pending_reqs.push_back(make_req(FN_INS_HEAD, 0, 32'hFFFF_FFFF, 0, 0));
        pending_reqs.push_back(make_req(FN_INS_TAIL, 32'hFFFF_FFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_INS_POS, 5, 32'hA5A5_A5A5, 0, 1));
        pending_reqs.push_back(make_req(FN_INS_KEY, 5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(make_req(FN_INS_POS, 7, 7, 0, CAPACITY - 1));
        pending_reqs.push_back(make_req(FN_GET_POS, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_GET_POS, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(FN_GET_KEY, 0, 0, 5, 0));
        pending_reqs.push_back(make_req(FN_EXISTS, 0, 0, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(make_req(FN_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, CAPACITY - 1));
        pending_reqs.push_back(make_req(FN_UNUSED_HI, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_DEL_KEY, 0, 0, 5, 0));
        pending_reqs.push_back(make_req(FN_DEL_POS, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(FN_DEL_HEAD, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_DEL_TAIL, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_DEL_POS, 0, 0, 0, CAPACITY - 1));
        wait_idle();

        // Fill toward full, then drain toward empty, under each idling mix.
        for (ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            repeat (100) pending_reqs.push_back(random_req(88, 6));
            repeat (90) pending_reqs.push_back(random_req(6, 88));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("array_list_table_engine_top verification clean");
        else
            $display("array_list_table_engine_top verification failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/alte_pkg.sv
rtl/alte_cell.sv
rtl/array_list_table_engine_top.sv
rtl/alte_check.sv
tb/array_list_table_engine_top_tb.sv
